// ===== src/fpfa_pkg.sv =====
// shared types, codes and constants of the fixed partition fit allocator
package fpfa_pkg;

   localparam int unsigned NUM_PARTITIONS_DEF = 8;
   localparam int unsigned SIZE_W             = 16;
   localparam int unsigned INDEX_W            = 3;
   localparam int unsigned MODE_W             = 2;
   localparam int unsigned WIDE_W             = 7;

   localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
   localparam logic [MODE_W-1:0] MODE_BEST  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_WORST = 2'd2;

   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_ALLOC = 1'b1;

   typedef struct packed {
      logic               req_type;
      logic [INDEX_W-1:0] load_index;
      logic [SIZE_W-1:0]  load_size;
      logic [SIZE_W-1:0]  request_size;
   } fpfa_req_type;

   typedef struct packed {
      logic               granted;
      logic [INDEX_W-1:0] partition_index;
      logic [SIZE_W-1:0]  partition_size;
   } fpfa_rsp_type;

   typedef struct packed {
      logic load_we;
      logic start;
      logic step;
      logic publish;
   } fpfa_cmd_type;

   typedef struct packed {
      logic scan_last;
      logic out_free;
   } fpfa_status_type;

endpackage

// ===== src/fixed_partition_fit_allocator_unit.sv =====
// top level of the fixed partition fit allocator
// A load beat writes one partition size and marks the slot free, with no response. A
// request beat scans the whole table, one partition per cycle through the single read
// port of the size ram, and returns one response beat: a request holds the block from
// acceptance until its result is published, and no new request is taken meanwhile;
// publishing also waits while a stalled rsp_ready keeps the output register full.
// fit_mode selects first, best or worst fit; the user must write it through csr_wr_en
// only while the block is idle, and the block itself does not enforce this.
module fixed_partition_fit_allocator_unit #(
   parameter int unsigned NUM_PARTITIONS = fpfa_pkg::NUM_PARTITIONS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  fpfa_pkg::fpfa_req_type      req_payload,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output fpfa_pkg::fpfa_rsp_type      rsp_payload,
   input  logic                        csr_wr_en,
   input  logic [fpfa_pkg::MODE_W-1:0] csr_wr_data
);

   fpfa_pkg::fpfa_cmd_type    cmd;
   fpfa_pkg::fpfa_status_type status;

   fpfa_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_is_alloc (req_payload.req_type),
      .req_ready    (req_ready),
      .cmd          (cmd),
      .status       (status)
   );

   fpfa_datapath #(
      .NUM_PARTITIONS (NUM_PARTITIONS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .rsp_ready   (rsp_ready),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .status      (status)
   );

endmodule

// ===== src/fpfa_ram.sv =====
// generic single write port ram with registered read
module fpfa_ram #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 8,
   localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/fpfa_datapath.sv =====
// partition table, free bits, scan compare and result register
module fpfa_datapath #(
   parameter int unsigned NUM_PARTITIONS = fpfa_pkg::NUM_PARTITIONS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  fpfa_pkg::fpfa_req_type          req_payload,
   input  logic                            rsp_ready,
   output logic                            rsp_valid,
   output fpfa_pkg::fpfa_rsp_type          rsp_payload,
   input  logic                            csr_wr_en,
   input  logic [fpfa_pkg::MODE_W-1:0]     csr_wr_data,
   input  fpfa_pkg::fpfa_cmd_type          cmd,
   output fpfa_pkg::fpfa_status_type       status
);

   localparam int unsigned IDX_W = (NUM_PARTITIONS > 1) ? $clog2(NUM_PARTITIONS) : 1;
   localparam int unsigned CNT_W = $clog2(NUM_PARTITIONS + 1);
   localparam logic [CNT_W-1:0] SCAN_END = CNT_W'(NUM_PARTITIONS);
   localparam logic [fpfa_pkg::WIDE_W-1:0] PART_LIMIT = fpfa_pkg::WIDE_W'(NUM_PARTITIONS);

   logic [fpfa_pkg::MODE_W-1:0] fit_mode_ff, fit_mode_in;
   logic [fpfa_pkg::SIZE_W-1:0] need_ff, need_in;
   logic [CNT_W-1:0]            scan_ff, scan_in;
   logic                        pick_valid_ff, pick_valid_in;
   logic [IDX_W-1:0]            pick_idx_ff, pick_idx_in;
   logic [fpfa_pkg::SIZE_W-1:0] best_ff, best_in;
   logic [NUM_PARTITIONS-1:0]   free_ff, free_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   fpfa_pkg::fpfa_rsp_type      rsp_ff, rsp_in;

   logic [fpfa_pkg::WIDE_W-1:0] ld_wide;
   logic                        ld_ok;
   logic [IDX_W-1:0]            ld_addr;
   logic                        ram_we;
   logic [IDX_W-1:0]            rd_addr;
   logic [fpfa_pkg::SIZE_W-1:0] rd_data;
   logic [CNT_W-1:0]            scan_prev;
   logic [IDX_W-1:0]            eval_idx;
   logic                        eval_on;
   logic                        fits;
   logic                        take;
   logic [fpfa_pkg::WIDE_W-1:0] pick_wide;

   assign ld_wide   = fpfa_pkg::WIDE_W'(req_payload.load_index);
   assign ld_ok     = ld_wide < PART_LIMIT;
   assign ld_addr   = ld_wide[IDX_W-1:0];
   assign ram_we    = cmd.load_we && ld_ok;
   assign rd_addr   = (scan_ff < SCAN_END) ? scan_ff[IDX_W-1:0] : '0;
   assign scan_prev = scan_ff - CNT_W'(1);
   assign eval_idx  = scan_prev[IDX_W-1:0];
   assign eval_on   = cmd.step && (scan_ff != '0);
   assign fits      = free_ff[eval_idx] && (rd_data >= need_ff);
   assign pick_wide = fpfa_pkg::WIDE_W'(pick_idx_ff);

   fpfa_ram #(
      .WIDTH (fpfa_pkg::SIZE_W),
      .DEPTH (NUM_PARTITIONS)
   ) u_size_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ld_addr),
      .wr_data (req_payload.load_size),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // placement policy, unknown mode falls back to first fit
   always_comb begin
      unique case (fit_mode_ff)
         fpfa_pkg::MODE_BEST: begin
            take = fits && (!pick_valid_ff || (rd_data < best_ff));
         end
         fpfa_pkg::MODE_WORST: begin
            take = fits && (!pick_valid_ff || (rd_data >= best_ff));
         end
         default: begin
            take = fits && !pick_valid_ff;
         end
      endcase
   end

   always_comb begin
      fit_mode_in   = fit_mode_ff;
      need_in       = need_ff;
      scan_in       = scan_ff;
      pick_valid_in = pick_valid_ff;
      pick_idx_in   = pick_idx_ff;
      best_in       = best_ff;
      free_in       = free_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_in        = rsp_ff;

      if (csr_wr_en) begin
         fit_mode_in = csr_wr_data;
      end
      if (ram_we) begin
         free_in[ld_addr] = 1'b1;
      end
      if (cmd.start) begin
         need_in       = req_payload.request_size;
         scan_in       = '0;
         pick_valid_in = 1'b0;
      end
      if (cmd.step) begin
         scan_in = scan_ff + CNT_W'(1);
      end
      if (eval_on && take) begin
         pick_valid_in = 1'b1;
         pick_idx_in   = eval_idx;
         best_in       = rd_data;
      end
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.publish) begin
         rsp_valid_in               = 1'b1;
         rsp_in.granted             = pick_valid_ff;
         rsp_in.partition_index     = pick_valid_ff ? pick_wide[fpfa_pkg::INDEX_W-1:0] : '0;
         rsp_in.partition_size      = pick_valid_ff ? best_ff : '0;
         if (pick_valid_ff) begin
            free_in[pick_idx_ff] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fit_mode_ff   <= fpfa_pkg::MODE_FIRST;
         scan_ff       <= '0;
         pick_valid_ff <= 1'b0;
         free_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         fit_mode_ff   <= fit_mode_in;
         scan_ff       <= scan_in;
         pick_valid_ff <= pick_valid_in;
         free_ff       <= free_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      need_ff     <= need_in;
      pick_idx_ff <= pick_idx_in;
      best_ff     <= best_in;
      rsp_ff      <= rsp_in;
   end

   assign status.scan_last = (scan_ff == SCAN_END);
   assign status.out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_payload      = rsp_ff;

`ifndef SYNTH
   a_grant_marks_used: assert property (@(posedge clock) disable iff (reset)
      $past(cmd.publish) && rsp_ff.granted |-> !free_ff[pick_idx_ff])
      else $error("granted partition still free");

   a_grant_fits: assert property (@(posedge clock) disable iff (reset)
      $past(cmd.publish) && rsp_ff.granted |-> rsp_ff.partition_size >= need_ff)
      else $error("granted partition smaller than request");

   a_no_fit_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.granted |->
         (rsp_ff.partition_index == '0) && (rsp_ff.partition_size == '0))
      else $error("refused beat carries non-zero fields");
`endif

endmodule

// ===== src/fpfa_ctrl.sv =====
// controller state machine sequencing loads, scans and result beats
module fpfa_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_is_alloc,
   output logic                      req_ready,
   output fpfa_pkg::fpfa_cmd_type    cmd,
   input  fpfa_pkg::fpfa_status_type status
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_is_alloc == fpfa_pkg::REQ_ALLOC) begin
                  cmd.start = 1'b1;
                  state_in  = ST_SCAN;
               end else begin
                  cmd.load_we = 1'b1;
               end
            end
         end
         ST_SCAN: begin
            cmd.step = 1'b1;
            if (status.scan_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.publish = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
